[hw/rtl/fdr_pkg.sv]
// Shared widths, latencies and payload types for the dielectric Fresnel pipeline.
// No dependencies; used by fdr_tsqrt, fdr_rdiv and fresnel_dielectric_reflectance.
package fdr_pkg;

	// quotient bits of the transmitted sin^2 divide, root bits of the cosine sqrt
	localparam int T_QBITS  = 28;
	localparam int SQ_STEPS = 15;
	localparam int T_LAT    = T_QBITS + SQ_STEPS;
	// quotient bits of each amplitude ratio (Q.30, one inclusive)
	localparam int R_QBITS  = 31;
	localparam int R_LAT    = R_QBITS;

	localparam logic [14:0] ONE_Q14  = 15'd16384;
	localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [15:0] REFL_ONE = 16'd32768;

	typedef logic [14:0] cos_t;    // absolute clamped cosine, Q.14
	typedef logic [15:0] eta_t;    // refractive index, Q4.12
	typedef logic [31:0] sq_t;     // index squared
	typedef logic [59:0] lhs_t;    // etaI^2 * sin^2, Q.28 scaled
	typedef logic [14:0] ct_t;     // transmitted cosine, Q.14
	typedef logic [29:0] rnum_t;   // ratio numerator magnitude
	typedef logic [30:0] rden_t;   // ratio denominator
	typedef logic [30:0] ratio_t;  // ratio magnitude, Q.30

	typedef struct packed {
		logic vld;
		logic tir;
		eta_t ei;
		eta_t et;
		cos_t c;
	} tside_t;

	typedef struct packed {
		logic vld;
		logic tir;
	} rside_t;

endpackage

[hw/rtl/fdr_tsqrt.sv]
// Pipelined restoring divide for transmitted sin^2 followed by a pipelined
// digit-by-digit square root giving the transmitted cosine. Depends on fdr_pkg.
module fdr_tsqrt (
	input  logic         clk,
	input  logic         en,
	input  fdr_pkg::lhs_t lhs,
	input  fdr_pkg::sq_t  dvs,
	output fdr_pkg::ct_t  ct
);
	import fdr_pkg::*;

	logic [31:0]        drem_s [T_QBITS];
	logic [T_QBITS-1:0] dlow_s [T_QBITS];
	logic [T_QBITS-1:0] dq_s   [T_QBITS];
	logic [31:0]        ddvs_s [T_QBITS];

	logic [17:0] srem_s  [SQ_STEPS];
	logic [14:0] sroot_s [SQ_STEPS];
	logic [29:0] svb_s   [SQ_STEPS];

	logic [29:0] v_rad;

	genvar k;
	generate
		// one quotient bit per stage; upper dividend half is already below the divisor
		for (k = 0; k < T_QBITS; k++) begin : g_div
			logic [31:0]        rem_in;
			logic [31:0]        dvs_in;
			logic [T_QBITS-1:0] low_in;
			logic [T_QBITS-1:0] q_in;
			logic [32:0]        trial;
			logic               ge;
			if (k == 0) begin : g_first
				assign rem_in = lhs[59:28];
				assign low_in = lhs[27:0];
				assign q_in   = '0;
				assign dvs_in = dvs;
			end else begin : g_next
				assign rem_in = drem_s[k-1];
				assign low_in = dlow_s[k-1];
				assign q_in   = dq_s[k-1];
				assign dvs_in = ddvs_s[k-1];
			end
			assign trial = {rem_in, low_in[T_QBITS-1]};
			assign ge    = trial >= {1'b0, dvs_in};
			always_ff @(posedge clk) begin
				if (en) begin
					drem_s[k] <= ge ? 32'(trial - {1'b0, dvs_in}) : trial[31:0];
					dlow_s[k] <= {low_in[T_QBITS-2:0], 1'b0};
					dq_s[k]   <= {q_in[T_QBITS-2:0], ge};
					ddvs_s[k] <= dvs_in;
				end
			end
		end

		// radicand 2^28 - t2, padded to an even bit count
		assign v_rad = {1'b0, 29'(ONE_Q28 - {1'b0, dq_s[T_QBITS-1]})};

		for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
			logic [17:0] rem_in;
			logic [14:0] root_in;
			logic [29:0] vb_in;
			logic [19:0] rem_sh;
			logic [19:0] trial;
			logic        ge;
			if (k == 0) begin : g_first
				assign rem_in  = '0;
				assign root_in = '0;
				assign vb_in   = v_rad;
			end else begin : g_next
				assign rem_in  = srem_s[k-1];
				assign root_in = sroot_s[k-1];
				assign vb_in   = svb_s[k-1];
			end
			assign rem_sh = {rem_in, vb_in[29:28]};
			assign trial  = {3'b000, root_in, 2'b01};
			assign ge     = rem_sh >= trial;
			always_ff @(posedge clk) begin
				if (en) begin
					srem_s[k]  <= ge ? 18'(rem_sh - trial) : rem_sh[17:0];
					sroot_s[k] <= {root_in[13:0], ge};
					svb_s[k]   <= {vb_in[27:0], 2'b00};
				end
			end
		end
	endgenerate

	assign ct = sroot_s[SQ_STEPS-1];

endmodule

[hw/rtl/fdr_rdiv.sv]
// Pipelined restoring divide num * 2^30 / den for one amplitude ratio (num <= den).
// Zero denominator yields one. Depends on fdr_pkg.
module fdr_rdiv (
	input  logic            clk,
	input  logic            en,
	input  fdr_pkg::rnum_t  num,
	input  fdr_pkg::rden_t  den,
	output fdr_pkg::ratio_t quo
);
	import fdr_pkg::*;

	logic [30:0]        rem_s  [R_QBITS];
	logic [30:0]        den_s  [R_QBITS];
	logic [R_QBITS-1:0] q_s    [R_QBITS];
	logic               zero_s [R_QBITS];

	genvar k;
	generate
		for (k = 0; k < R_QBITS; k++) begin : g_step
			logic [31:0]        rem_in;
			logic [30:0]        den_in;
			logic [R_QBITS-1:0] q_in;
			logic               zero_in;
			logic               ge;
			if (k == 0) begin : g_first
				assign rem_in  = {2'b00, num};
				assign den_in  = den;
				assign q_in    = '0;
				assign zero_in = den == '0;
			end else begin : g_next
				assign rem_in  = {rem_s[k-1], 1'b0};
				assign den_in  = den_s[k-1];
				assign q_in    = q_s[k-1];
				assign zero_in = zero_s[k-1];
			end
			assign ge = rem_in >= {1'b0, den_in};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? 31'(rem_in - {1'b0, den_in}) : rem_in[30:0];
					den_s[k]  <= den_in;
					q_s[k]    <= {q_in[R_QBITS-2:0], ge};
					zero_s[k] <= zero_in;
				end
			end
		end
	endgenerate

	assign quo = zero_s[R_QBITS-1] ? ONE_Q30 : q_s[R_QBITS-1];

endmodule

[hw/rtl/fresnel_dielectric_reflectance.sv]
// Unpolarized Fresnel reflectance at a dielectric interface, fully pipelined.
// Depends on fdr_pkg, fdr_tsqrt and fdr_rdiv.
//
// One word in, one word out, one word per clock sustained while the output
// register is empty or being taken. Stages: three front stages (clamp and
// swap, squares, sin^2 scaling), 28 divide stages for the transmitted sin^2
// plus 15 square-root stages for the transmitted cosine, two stages forming the
// ratio terms, 31 divide stages per amplitude ratio, then squaring and the
// rounded mean. The whole pipe advances together whenever the output register
// is empty or being taken, so a downstream stall freezes every stage in place
// and nothing is dropped or duplicated. Total internal reflection words carry
// reflectance one and the tuser flag set.
module fresnel_dielectric_reflectance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cos_incident[15:0], eta_incident[31:16], eta_transmitted[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reflectance[15:0]
	output logic        m_tuser    // total_internal
);
	import fdr_pkg::*;

	logic en;

	// input fields
	logic signed [15:0] cs_in;
	eta_t               ei_in;
	eta_t               et_in;
	logic               pos;
	cos_t               c_in;

	// stage 1: clamp, swap
	logic vld_s1;
	cos_t c_s1;
	eta_t ei_s1, et_s1;

	// stage 2: squares
	logic        vld_s2;
	logic [28:0] s2v_s2;
	sq_t         ei2_s2, et2_s2;
	cos_t        c_s2;
	eta_t        ei_s2, et_s2;

	// stage 3: etaI^2 * sin^2
	logic vld_s3;
	lhs_t lhs_s3;
	sq_t  et2_s3;
	cos_t c_s3;
	eta_t ei_s3, et_s3;
	logic tir_s3;

	tside_t tside_s [T_LAT];
	ct_t    ct;

	// stage 4: products
	logic        vld_s4, tir_s4;
	logic [29:0] x1_s4, y1_s4, x2_s4, y2_s4;

	// stage 5: ratio operands
	logic  vld_s5, tir_s5;
	rnum_t num1_s5, num2_s5;
	rden_t den1_s5, den2_s5;

	rside_t rside_s [R_LAT];
	ratio_t r1, r2;

	// stage 6: squared ratios
	logic        vld_s6, tir_s6;
	logic [60:0] sq1_s6, sq2_s6;

	// stage 7: output register
	logic        vld_s7, tir_s7;
	logic [15:0] refl_s7;

	logic [61:0] sum;
	logic [16:0] rnd;

	// the pipe moves as a whole; the output register frees on a take
	assign en       = !vld_s7 || m_tready;
	assign s_tready = en;

	assign cs_in = s_tdata[15:0];
	assign ei_in = s_tdata[31:16];
	assign et_in = s_tdata[47:32];
	// zero cosine counts as leaving the medium
	assign pos   = cs_in > 16'sd0;

	always_comb begin
		if (cs_in >= $signed({1'b0, ONE_Q14})) begin
			c_in = ONE_Q14;
		end else if (cs_in <= -$signed({1'b0, ONE_Q14})) begin
			c_in = ONE_Q14;
		end else if (pos) begin
			c_in = cs_in[14:0];
		end else begin
			c_in = 15'(-cs_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= tside_s[T_LAT-1].vld;
			vld_s5 <= vld_s4;
			vld_s6 <= rside_s[R_LAT-1].vld;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= c_in;
			ei_s1  <= pos ? ei_in : et_in;
			et_s1  <= pos ? et_in : ei_in;

			s2v_s2 <= 29'(ONE_Q28 - 29'(c_s1 * c_s1));
			ei2_s2 <= ei_s1 * ei_s1;
			et2_s2 <= et_s1 * et_s1;
			c_s2   <= c_s1;
			ei_s2  <= ei_s1;
			et_s2  <= et_s1;

			lhs_s3 <= 60'(ei2_s2 * s2v_s2);
			et2_s3 <= et2_s2;
			c_s3   <= c_s2;
			ei_s3  <= ei_s2;
			et_s3  <= et_s2;
		end
	end

	// sinT >= 1, compared exactly in Q.28
	assign tir_s3 = lhs_s3 >= {et2_s3, 28'd0};

	fdr_tsqrt u_tsqrt (
		.clk (clk),
		.en  (en),
		.lhs (lhs_s3),
		.dvs (et2_s3),
		.ct  (ct)
	);

	// side data follows the divide/sqrt pipe
	genvar k;
	generate
		for (k = 0; k < T_LAT; k++) begin : g_tside
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						tside_s[k] <= '0;
					end else if (en) begin
						tside_s[k] <= '{vld: vld_s3, tir: tir_s3, ei: ei_s3, et: et_s3, c: c_s3};
					end
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						tside_s[k] <= '0;
					end else if (en) begin
						tside_s[k] <= tside_s[k-1];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s4  <= tside_s[T_LAT-1].tir;
			x1_s4   <= 30'(tside_s[T_LAT-1].et * tside_s[T_LAT-1].c);
			y1_s4   <= 30'(tside_s[T_LAT-1].ei * ct);
			x2_s4   <= 30'(tside_s[T_LAT-1].ei * tside_s[T_LAT-1].c);
			y2_s4   <= 30'(tside_s[T_LAT-1].et * ct);

			tir_s5  <= tir_s4;
			den1_s5 <= {1'b0, x1_s4} + {1'b0, y1_s4};
			den2_s5 <= {1'b0, x2_s4} + {1'b0, y2_s4};
			num1_s5 <= (x1_s4 >= y1_s4) ? x1_s4 - y1_s4 : y1_s4 - x1_s4;
			num2_s5 <= (x2_s4 >= y2_s4) ? x2_s4 - y2_s4 : y2_s4 - x2_s4;
		end
	end

	fdr_rdiv u_rdiv_par (
		.clk (clk),
		.en  (en),
		.num (num1_s5),
		.den (den1_s5),
		.quo (r1)
	);

	fdr_rdiv u_rdiv_perp (
		.clk (clk),
		.en  (en),
		.num (num2_s5),
		.den (den2_s5),
		.quo (r2)
	);

	generate
		for (k = 0; k < R_LAT; k++) begin : g_rside
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						rside_s[k] <= '0;
					end else if (en) begin
						rside_s[k] <= '{vld: vld_s5, tir: tir_s5};
					end
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						rside_s[k] <= '0;
					end else if (en) begin
						rside_s[k] <= rside_s[k-1];
					end
				end
			end
		end
	endgenerate

	// mean of squares, rounded half up into Q.15
	assign sum = {1'b0, sq1_s6} + {1'b0, sq2_s6};
	assign rnd = 17'((sum + 62'(64'd1 << 45)) >> 46);

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s6  <= rside_s[R_LAT-1].tir;
			sq1_s6  <= 61'(r1 * r1);
			sq2_s6  <= 61'(r2 * r2);

			tir_s7  <= tir_s6;
			if (tir_s6 || rnd > {1'b0, REFL_ONE}) begin
				refl_s7 <= REFL_ONE;
			end else begin
				refl_s7 <= rnd[15:0];
			end
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = refl_s7;
	assign m_tuser  = tir_s7;

	a_tir_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == REFL_ONE)
		else $error("tir word without unit reflectance");

	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= REFL_ONE)
		else $error("reflectance above one");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s3) && $stable(vld_s5) && $stable(tside_s[T_LAT-1].vld))
		else $error("pipe moved during stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output word changed");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for fresnel_dielectric_reflectance: directed table then random words.
// Depends on fdr_pkg and the RTL of the Fresnel pipeline; reads no files.
`timescale 1ns / 100ps

module tb_top;
	import fdr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // cos_incident[15:0], eta_incident[31:16], eta_transmitted[47:32]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // reflectance[15:0]
	logic        m_tuser;   // total_internal

	typedef struct packed {
		logic [15:0] refl;
		logic        tir;
	} refl_word_t;

	typedef struct {
		logic signed [15:0] cos_in;
		eta_t               eta_i;
		eta_t               eta_t_side;
		bit                 typed;   // expected value given in the row
		logic [15:0]        refl;
		logic               tir;
	} stim_row_t;

	refl_word_t pending_refl[$];
	int         mismatches;
	bit         quiet;        // no idling on either side
	bit         row_typed;    // typed expectation travels with the word on the bus
	refl_word_t row_word;
	stim_row_t  rows[$];

	fresnel_dielectric_reflectance DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor(sqrt(v)), bit-serial
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// |x - y| / (x + y) in Q.30, one when both are zero
	function automatic longint unsigned amp_ratio(longint unsigned x, longint unsigned y);
		longint unsigned sum;
		longint unsigned diff;
		sum  = x + y;
		diff = (x >= y) ? x - y : y - x;
		if (sum == 0)
			return 64'd1 << 30;
		return (diff << 30) / sum;
	endfunction

	function automatic refl_word_t fresnel_refl(logic [47:0] word);
		int              cs;
		longint unsigned ei, et, swap, c, s2, lhs, rhs, t2, ct, r1, r2, refl;
		refl_word_t      res;
		cs = $signed(word[15:0]);
		ei = word[31:16];
		et = word[47:32];
		if (cs > 16384)
			cs = 16384;
		if (cs < -16384)
			cs = -16384;
		// leaving the medium (zero cosine too): swap sides, use |cos|
		if (cs > 0) begin
			c = cs;
		end else begin
			swap = ei;
			ei   = et;
			et   = swap;
			c    = -cs;
		end
		s2  = (64'd1 << 28) - c * c;
		lhs = ei * ei * s2;
		rhs = (et * et) << 28;
		if (lhs >= rhs) begin
			res.refl = REFL_ONE;
			res.tir  = 1'b1;
			return res;
		end
		t2 = lhs / (et * et);
		if (t2 > (64'd1 << 28))
			t2 = 64'd1 << 28;
		ct   = int_sqrt((64'd1 << 28) - t2);
		r1   = amp_ratio(et * c, ei * ct);
		r2   = amp_ratio(ei * c, et * ct);
		refl = (r1 * r1 + r2 * r2 + (64'd1 << 45)) >> 46;
		if (refl > 32768)
			refl = 32768;
		res.refl = refl[15:0];
		res.tir  = 1'b0;
		return res;
	endfunction

	function automatic void add_row(int cs, int ei, int et, bit typed, int refl, bit tir);
		stim_row_t r;
		r.cos_in     = cs[15:0];
		r.eta_i      = ei[15:0];
		r.eta_t_side = et[15:0];
		r.typed      = typed;
		r.refl       = refl[15:0];
		r.tir        = tir;
		rows.push_back(r);
	endfunction

	// expectation taken when a word is accepted
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_refl.push_back(row_typed ? row_word : fresnel_refl(s_tdata));
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		refl_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_refl.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: refl=%0d tir=%0b", m_tdata, m_tuser);
			end else begin
				want = pending_refl.pop_front();
				if (m_tdata !== want.refl || m_tuser !== want.tir) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
							want.refl, want.tir, m_tdata, m_tuser);
				end
			end
		end
	end

	// receiver stalls at random, about 12 percent of the time, never while quiet
	always @(negedge clk)
		m_tready = quiet || ($urandom_range(99) >= 12);

	// random word: mostly realistic indices near 1..3, rest full range
	task automatic random_row();
		int cs, ei, et;
		case ($urandom_range(9))
			0: cs = $urandom_range(65535);          // includes values beyond one
			1: cs = $urandom_range(2) * 16384 - 16384;
			default: cs = $urandom_range(32768) - 16384;
		endcase
		if ($urandom_range(3) == 0) begin
			ei = $urandom_range(65535);
			et = $urandom_range(65535);
		end else begin
			ei = $urandom_range(12288, 4096);
			et = $urandom_range(12288, 4096);
		end
		add_row(cs, ei, et, 1'b0, 0, 1'b0);
	endtask

	initial begin
		stim_row_t r;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		quiet     = 1'b0;
		row_typed = 1'b0;
		row_word  = '0;
		mismatches = 0;

		// directed table: cos, etaI, etaT, typed?, refl, tir
		add_row(16384, 4096, 4096, 1, 0, 0);          // normal incidence, matched indices
		add_row(16384, 65535, 65535, 1, 0, 0);
		add_row(-16384, 6144, 6144, 1, 0, 0);         // leaving, matched
		add_row(32767, 4096, 6144, 0, 0, 0);          // beyond one, clamped high
		add_row(-32768, 4096, 6144, 0, 0, 0);         // beyond minus one, clamped low
		add_row(16384, 4096, 6144, 0, 0, 0);
		add_row(-16384, 4096, 6144, 0, 0, 0);
		add_row(0, 4096, 6144, 1, 32768, 1);          // grazing: swapped, total reflection
		add_row(0, 6144, 4096, 0, 0, 0);
		add_row(8192, 6144, 4096, 0, 0, 0);
		add_row(1, 65535, 1, 1, 32768, 1);            // dense to thin, near grazing
		add_row(8000, 6144, 0, 1, 32768, 1);          // zero transmitted index
		add_row(16384, 0, 0, 1, 32768, 1);            // both indices zero
		add_row(0, 5, 0, 1, 32768, 0);                // zero ratio denominator
		add_row(16384, 0, 4096, 1, 32768, 0);         // zero incident index
		add_row(-1, 1, 65535, 0, 0, 0);
		add_row(12000, 1, 65535, 0, 0, 0);
		add_row(12000, 65535, 1, 1, 32768, 1);
		add_row(16383, 4096, 5461, 0, 0, 0);
		add_row(-8192, 4096, 5461, 0, 0, 0);
		add_row(16384, 1, 1, 1, 0, 0);
		for (int i = 0; i < 1150; i++)
			random_row();

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < rows.size(); i++) begin
			r = rows[i];
			quiet = (i >= 400 && i < 600);
			while (!quiet && $urandom_range(99) < 12) begin
				s_tvalid = 1'b0;
				@(negedge clk);
			end
			s_tvalid  = 1'b1;
			s_tdata   = {r.eta_t_side, r.eta_i, r.cos_in};
			row_typed = r.typed;
			row_word  = {r.refl, r.tir};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			@(negedge clk);
		end
		s_tvalid = 1'b0;

		while (pending_refl.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule

[fresnel_dielectric_reflectance.f]
hw/rtl/fdr_pkg.sv
hw/rtl/fdr_tsqrt.sv
hw/rtl/fdr_rdiv.sv
hw/rtl/fresnel_dielectric_reflectance.sv
tb/tb_top.sv
